FILE: hw/rtl/nsks_pkg.sv
`timescale 1ns / 1ps

package nsks_pkg;

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_INSERT  = 2'd1;
  localparam logic [1:0] REQ_READOUT = 2'd2;

  localparam int FIELD_W = 32;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] item_index;
    logic [FIELD_W-1:0] distance_key;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] entry_index;
    logic [FIELD_W-1:0] entry_key;
    logic [RANK_W-1:0]  entry_rank;
    logic               entry_valid;
    logic               inserted;
    logic [COUNT_W-1:0] list_count;
    logic               last_of_run;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic report;
    logic read_step;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic read_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/nsks_ctrl.sv
`timescale 1ns / 1ps

module nsks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  nsks_pkg::dp_stat_t  stat,
  output nsks_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                rsp_valid
);

  typedef enum logic {
    IDLE,
    READ
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == IDLE);
  assign busy   = (state == READ);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          case (req_type)
            nsks_pkg::REQ_CLEAR:  cmd.clear  = 1'b1;
            nsks_pkg::REQ_INSERT: cmd.insert = 1'b1;
            nsks_pkg::REQ_READOUT: begin
              if (stat.empty) begin
                cmd.report = 1'b1;
              end else begin
                state_next = READ;
              end
            end
            default: cmd.report = 1'b1;
          endcase
        end
      end
      READ: begin
        cmd.read_step = 1'b1;
        if (stat.read_last) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= cmd.clear || cmd.insert || cmd.report || cmd.read_step;
    end
  end

endmodule

FILE: hw/rtl/nsks_dp.sv
`timescale 1ns / 1ps

module nsks_dp #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nsks_pkg::req_t                req,
  input  nsks_pkg::dp_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [nsks_pkg::CAP_W-1:0]    cfg_wdata,
  output nsks_pkg::dp_stat_t            stat,
  output nsks_pkg::rsp_t                rsp
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = $clog2(MAX_ENTRIES);
  localparam int XW = (CW > nsks_pkg::CAP_W) ? CW : nsks_pkg::CAP_W;

  logic [KEY_BITS-1:0]         cell_key [MAX_ENTRIES];
  logic [nsks_pkg::FIELD_W-1:0] cell_idx [MAX_ENTRIES];
  logic [KEY_BITS-1:0]         ins_key  [MAX_ENTRIES];
  logic [nsks_pkg::FIELD_W-1:0] ins_idx  [MAX_ENTRIES];
  logic [KEY_BITS-1:0]         rot_key  [MAX_ENTRIES];
  logic [nsks_pkg::FIELD_W-1:0] rot_idx  [MAX_ENTRIES];

  logic [nsks_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0]              total;
  logic [RW-1:0]              rank;

  logic [CW-1:0]          eff_cap;
  logic [CW-1:0]          held;
  logic [CW-1:0]          total_m1;
  logic                   full;
  logic                   reject;
  logic [CW-1:0]          ins_count;
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] lt;
  logic [KEY_BITS-1:0]    cand_key;
  nsks_pkg::rsp_t         rsp_next;

  assign cand_key = KEY_BITS'(req.distance_key);
  assign total_m1 = total - CW'(1);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (XW'(capacity) > XW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
    held      = (total > eff_cap) ? eff_cap : total;
    full      = (held == eff_cap);
    reject    = full && ((lt ^ valid) == '0);
    ins_count = full ? held : held + CW'(1);
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic gt;
      assign valid[g] = (CW'(g) < held);
      assign gt = (cell_key[g] > cand_key) ||
                  ((cell_key[g] == cand_key) && (cell_idx[g] > req.item_index));
      assign lt[g] = valid[g] && !gt;

      if (g == 0) begin : g_head
        assign ins_key[g] = lt[g] ? cell_key[g] : cand_key;
        assign ins_idx[g] = lt[g] ? cell_idx[g] : req.item_index;
      end else begin : g_body
        assign ins_key[g] = lt[g] ? cell_key[g] :
                            (lt[g-1] ? cand_key : cell_key[g-1]);
        assign ins_idx[g] = lt[g] ? cell_idx[g] :
                            (lt[g-1] ? req.item_index : cell_idx[g-1]);
      end

      if (g == MAX_ENTRIES - 1) begin : g_tail
        assign rot_key[g] = cell_key[0];
        assign rot_idx[g] = cell_idx[0];
      end else begin : g_mid
        assign rot_key[g] = (CW'(g) == total_m1) ? cell_key[0] : cell_key[g+1];
        assign rot_idx[g] = (CW'(g) == total_m1) ? cell_idx[0] : cell_idx[g+1];
      end
    end
  endgenerate

  assign stat.empty     = (total == '0);
  assign stat.read_last = (CW'(rank) == total_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= nsks_pkg::CAP_RESET;
      total    <= '0;
      rank     <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.clear) begin
        total <= '0;
      end else if (cmd.insert) begin
        total <= reject ? held : ins_count;
      end
      rank <= cmd.read_step ? rank + RW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cmd.insert && !reject) begin
        cell_key[i] <= ins_key[i];
        cell_idx[i] <= ins_idx[i];
      end else if (cmd.read_step) begin
        cell_key[i] <= rot_key[i];
        cell_idx[i] <= rot_idx[i];
      end
    end
  end

  always_comb begin
    rsp_next = rsp;
    if (cmd.clear) begin
      rsp_next             = '0;
      rsp_next.last_of_run = 1'b1;
    end else if (cmd.insert) begin
      rsp_next             = '0;
      rsp_next.inserted    = !reject;
      rsp_next.list_count  = nsks_pkg::COUNT_W'(reject ? held : ins_count);
      rsp_next.last_of_run = 1'b1;
    end else if (cmd.report) begin
      rsp_next             = '0;
      rsp_next.list_count  = nsks_pkg::COUNT_W'(total);
      rsp_next.last_of_run = 1'b1;
    end else if (cmd.read_step) begin
      rsp_next.entry_index = cell_idx[0];
      rsp_next.entry_key   = nsks_pkg::FIELD_W'(cell_key[0]);
      rsp_next.entry_rank  = nsks_pkg::RANK_W'(rank);
      rsp_next.entry_valid = 1'b1;
      rsp_next.inserted    = 1'b0;
      rsp_next.list_count  = nsks_pkg::COUNT_W'(total);
      rsp_next.last_of_run = stat.read_last;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

FILE: hw/rtl/top_n_smallest_key_selector.sv
`timescale 1ns / 1ps
// Clear, insert, unused codes and readout of an empty list: word accepted at one
// edge, result strobed the next cycle; busy stays low, so one such request per cycle
// (parallel compare cells). Readout of n entries: busy while reading, results registered
// from each read step, one per cycle, taken from the head cell while the list rotates
// back into place. The receiver cannot stall; results appear for exactly one cycle on
// rsp_valid. Synchronous reset: list empty, capacity 16, no result pending.

module top_n_smallest_key_selector #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  nsks_pkg::req_t             req,
  output logic                       rsp_valid,
  output nsks_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [nsks_pkg::CAP_W-1:0] cfg_wdata
);

  nsks_pkg::dp_cmd_t  cmd;
  nsks_pkg::dp_stat_t stat;

  nsks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req.req_type),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .rsp_valid (rsp_valid)
  );

  nsks_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/nsks_checker.sv
`timescale 1ns / 1ps

module nsks_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input nsks_pkg::req_t             req,
  input logic                       rsp_valid,
  input nsks_pkg::rsp_t             rsp
);

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type != nsks_pkg::REQ_READOUT))
      |=> (rsp_valid && rsp.last_of_run))
    else $error("non-readout word did not give one final result");

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last_of_run) |=> (rsp_valid && rsp.entry_valid))
    else $error("readout run broken");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.entry_valid) |-> rsp.last_of_run)
    else $error("invalid entry not flagged last");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.inserted) |-> (!rsp.entry_valid && (rsp.list_count != '0)))
    else $error("kept candidate with empty list");

  a_read_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (rsp_valid && rsp.entry_valid && rsp.last_of_run))
    else $error("readout ended without final entry");

endmodule

bind top_n_smallest_key_selector nsks_checker u_nsks_checker (.*);
